[rtl/acp_pkg.sv]
// Shared types, character codes and helpers for the ASCII CAN command parser.
`default_nettype none

package acp_pkg;

   // Default number of stored line bytes after which a line is dropped
   localparam int LINE_DEPTH_DEF = 32;

   // Character codes
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_BEL   = 8'h07;
   localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
   localparam logic [7:0] CH_ONE   = 8'h31;   // '1'
   localparam logic [7:0] CH_SEVEN = 8'h37;   // '7'
   localparam logic [7:0] CH_EIGHT = 8'h38;   // '8'
   localparam logic [7:0] CH_UPF   = 8'h46;   // 'F'
   localparam logic [7:0] CH_UNDER = 8'h5F;   // '_'
   localparam logic [7:0] CH_LOWD  = 8'h64;   // 'd'
   localparam logic [7:0] CH_LOWF  = 8'h66;   // 'f'
   localparam logic [7:0] CH_LOWU  = 8'h75;   // 'u'

   // Command letters
   localparam logic [7:0] CMD_NONE    = 8'h00;
   localparam logic [7:0] CMD_BITRATE = 8'h53;   // 'S'
   localparam logic [7:0] CMD_OPEN    = 8'h4F;   // 'O'
   localparam logic [7:0] CMD_LISTEN  = 8'h4C;   // 'L'
   localparam logic [7:0] CMD_CLOSE   = 8'h43;   // 'C'
   localparam logic [7:0] CMD_VER_HW  = 8'h56;   // 'V'
   localparam logic [7:0] CMD_VER_SW  = 8'h76;   // 'v'
   localparam logic [7:0] CMD_SERIAL  = 8'h4E;   // 'N'
   localparam logic [7:0] CMD_EXT_TX  = 8'h54;   // 'T'
   localparam logic [7:0] CMD_STD_TX  = 8'h74;   // 't'
   localparam logic [7:0] CMD_BOOT    = 8'h5F;   // '_'

   // Identifier digit counts and frame limits
   localparam logic [3:0] ID_DIGITS_EXT = 4'd8;
   localparam logic [3:0] ID_DIGITS_STD = 4'd3;
   localparam int         DATA_NIBBLES  = 16;

   // Index of the final item of a string reply and of a single reply
   localparam logic [2:0] LAST_ITEM_LONG  = 3'd5;
   localparam logic [2:0] LAST_ITEM_SHORT = 3'd0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic       store;       // non-CR byte accepted
      logic       start;       // CR accepted, begin line decode
      logic       rd_en;       // read line memory
      logic       emit_load;   // load one result into output register
      logic       finish;      // final result loaded, clear the line
      logic [2:0] emit_idx;    // result item number
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic is_cr;        // incoming byte is a carriage return
      logic six_items;    // current command answers with a six-byte string
   } dp_status_type;

   // Decode one ASCII hex digit; anything else reads as zero
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [3:0] r;
      r = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = 4'(c - 8'h57);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/acp_ctrl.sv]
// Controller state machine: handshakes, line memory scan and result sequencing.
`default_nettype none

module acp_ctrl #(
   parameter int LINE_DEPTH = acp_pkg::LINE_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   input  wire acp_pkg::dp_status_type         status,
   input  wire logic [$clog2(LINE_DEPTH+1)-1:0] line_len,
   output acp_pkg::dp_cmd_type                 cmd,
   output logic [$clog2(LINE_DEPTH)-1:0]       rd_addr
);

   localparam int LW = $clog2(LINE_DEPTH + 1);
   localparam int AW = $clog2(LINE_DEPTH);

   acp_pkg::state_type state_ff, state_in;
   logic [LW-1:0]      scan_ff, scan_in;
   logic [2:0]         emit_ff, emit_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic accept;
   logic slot_free;
   logic last_item;
   logic scan_last;

   assign accept    = req_valid && (state_ff == acp_pkg::ST_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign last_item = (emit_ff == (status.six_items ? acp_pkg::LAST_ITEM_LONG
                                                    : acp_pkg::LAST_ITEM_SHORT));
   assign scan_last = ((scan_ff + LW'(1)) == line_len);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         acp_pkg::ST_IDLE: begin
            if (accept && status.is_cr) begin
               state_in = (line_len == '0) ? acp_pkg::ST_EMIT : acp_pkg::ST_SCAN;
            end
         end
         acp_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = acp_pkg::ST_DRAIN;
            end
         end
         acp_pkg::ST_DRAIN: begin
            state_in = acp_pkg::ST_EMIT;
         end
         acp_pkg::ST_EMIT: begin
            if (slot_free && last_item) begin
               state_in = acp_pkg::ST_IDLE;
            end
         end
         default: state_in = acp_pkg::ST_IDLE;
      endcase
   end

   // Outputs to datapath and handshake
   always_comb begin
      cmd           = '0;
      cmd.store     = accept && !status.is_cr;
      cmd.start     = accept && status.is_cr;
      cmd.rd_en     = (state_ff == acp_pkg::ST_SCAN);
      cmd.emit_load = (state_ff == acp_pkg::ST_EMIT) && slot_free;
      cmd.finish    = cmd.emit_load && last_item;
      cmd.emit_idx  = emit_ff;
      rd_addr       = scan_ff[AW-1:0];
      req_stall     = (state_ff != acp_pkg::ST_IDLE);
   end

   // Counters and output valid
   always_comb begin
      scan_in      = scan_ff;
      emit_in      = emit_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.start) begin
         scan_in = '0;
         emit_in = '0;
      end else begin
         if (cmd.rd_en) begin
            scan_in = scan_ff + LW'(1);
         end
         if (cmd.emit_load) begin
            emit_in = emit_ff + 3'd1;
         end
      end
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acp_pkg::ST_IDLE;
         scan_ff      <= '0;
         emit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         emit_ff      <= emit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[rtl/acp_dpath.sv]
// Datapath: line memory, command state, hex decode, checks and result register.
`default_nettype none

module acp_dpath #(
   parameter int LINE_DEPTH = acp_pkg::LINE_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire acp_pkg::dp_cmd_type            cmd,
   input  wire logic [$clog2(LINE_DEPTH)-1:0]  rd_addr,
   input  wire logic [7:0]                     req_rx_byte,
   input  wire logic                           req_mailbox_free,
   output acp_pkg::dp_status_type              status,
   output logic [$clog2(LINE_DEPTH+1)-1:0]     line_len,
   output logic                                rsp_has_byte,
   output logic [7:0]                          rsp_resp_byte,
   output logic                                rsp_last,
   output logic                                rsp_frame_valid,
   output logic                                rsp_frame_extended,
   output logic [28:0]                         rsp_frame_id,
   output logic [3:0]                          rsp_frame_dlc,
   output logic [63:0]                         rsp_frame_data,
   output logic                                rsp_bitrate_valid,
   output logic [3:0]                          rsp_bitrate_index,
   output logic                                rsp_bus_open,
   output logic                                rsp_bootloader_request
);

   localparam int LW = $clog2(LINE_DEPTH + 1);
   localparam int AW = $clog2(LINE_DEPTH);

   // Line memory
   logic [7:0] line_mem [LINE_DEPTH];

   // Line state
   logic [7:0]    letter_ff, letter_in;
   logic [LW-1:0] len_ff, len_in;
   logic          open_ff, open_in;

   // Scan pipeline and decode accumulators
   logic [7:0]    rdata_ff;
   logic [AW-1:0] rd_idx_ff;
   logic          rd_vld_ff;
   logic [7:0]    b0_ff;
   logic [7:0]    dlc_byte_ff;
   logic [3:1]    dfu_ff;
   logic [28:0]   id_ff;
   logic [63:0]   data_ff;
   logic          mb_ff;

   // Result register
   logic          has_ff;
   logic [7:0]    byte_ff;
   logic          last_ff;
   logic          fv_ff;
   logic          fext_ff;
   logic [28:0]   fid_ff;
   logic [3:0]    fdlc_ff;
   logic [63:0]   fdata_ff;
   logic          bv_ff;
   logic [3:0]    bidx_ff;
   logic          copen_ff;
   logic          boot_ff;

   logic       is_ext;
   logic [3:0] idn;
   logic [7:0] max_first;
   logic [3:0] nib;
   logic       is_id_digit;
   logic       is_dlc_digit;
   logic       is_data_digit;
   logic [3:0] data_slot;

   logic       six;
   logic       s_ok;
   logic       frame_ok;
   logic       dfu_ok;
   logic       ack_only;
   logic [3:0] dlc;
   logic [7:0] resp0;
   logic [7:0] fill_char;
   logic [7:0] end_char;
   logic [7:0] item_byte;
   logic       item_last;

   assign status.is_cr     = (req_rx_byte == acp_pkg::CH_CR);
   assign six              = (letter_ff == acp_pkg::CMD_VER_HW) ||
                             (letter_ff == acp_pkg::CMD_VER_SW) ||
                             (letter_ff == acp_pkg::CMD_SERIAL);
   assign status.six_items = six;
   assign line_len         = len_ff;

   // Store incoming bytes and track the line
   always_comb begin
      letter_in = letter_ff;
      len_in    = len_ff;
      open_in   = open_ff;
      if (cmd.store) begin
         if (letter_ff != acp_pkg::CMD_NONE) begin
            if (len_ff == LW'(LINE_DEPTH - 1)) begin
               // drop an overlong line
               letter_in = acp_pkg::CMD_NONE;
               len_in    = '0;
            end else begin
               len_in = len_ff + LW'(1);
            end
         end else begin
            letter_in = req_rx_byte;
         end
      end
      if (cmd.start) begin
         if (letter_ff == acp_pkg::CMD_OPEN || letter_ff == acp_pkg::CMD_LISTEN) begin
            open_in = 1'b1;
         end else if (letter_ff == acp_pkg::CMD_CLOSE) begin
            open_in = 1'b0;
         end
      end
      if (cmd.finish) begin
         letter_in = acp_pkg::CMD_NONE;
         len_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_ff <= acp_pkg::CMD_NONE;
         len_ff    <= '0;
         open_ff   <= 1'b0;
      end else begin
         letter_ff <= letter_in;
         len_ff    <= len_in;
         open_ff   <= open_in;
      end
   end

   // Line memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.store && letter_ff != acp_pkg::CMD_NONE) begin
         line_mem[len_ff[AW-1:0]] <= req_rx_byte;
      end
      if (cmd.rd_en) begin
         rdata_ff <= line_mem[rd_addr];
      end
      rd_idx_ff <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
      end
   end

   // Classify the byte read back by its position in the line
   assign is_ext        = (letter_ff == acp_pkg::CMD_EXT_TX);
   assign idn           = is_ext ? acp_pkg::ID_DIGITS_EXT : acp_pkg::ID_DIGITS_STD;
   assign max_first     = is_ext ? acp_pkg::CH_ONE : acp_pkg::CH_SEVEN;
   assign nib           = acp_pkg::hex_nibble(rdata_ff);
   assign is_id_digit   = (rd_idx_ff < AW'(idn));
   assign is_dlc_digit  = (rd_idx_ff == AW'(idn));
   assign is_data_digit = (rd_idx_ff > AW'(idn)) &&
                          (rd_idx_ff <= AW'(idn) + AW'(acp_pkg::DATA_NIBBLES));
   // even digit is the high nibble of its byte
   assign data_slot     = 4'(rd_idx_ff - AW'(idn) - AW'(1)) ^ 4'd1;

   // Accumulate identifier, data and check bytes
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         b0_ff       <= '0;
         dlc_byte_ff <= '0;
         dfu_ff      <= '0;
         id_ff       <= '0;
         data_ff     <= '0;
         mb_ff       <= req_mailbox_free;
      end else if (rd_vld_ff) begin
         if (rd_idx_ff == AW'(0)) begin
            b0_ff <= rdata_ff;
         end
         if (rd_idx_ff == AW'(1)) begin
            dfu_ff[1] <= (rdata_ff == acp_pkg::CH_LOWD);
         end
         if (rd_idx_ff == AW'(2)) begin
            dfu_ff[2] <= (rdata_ff == acp_pkg::CH_LOWF);
         end
         if (rd_idx_ff == AW'(3)) begin
            dfu_ff[3] <= (rdata_ff == acp_pkg::CH_LOWU);
         end
         if (is_id_digit) begin
            id_ff <= {id_ff[24:0], nib};
         end
         if (is_dlc_digit) begin
            dlc_byte_ff <= rdata_ff;
         end
         if (is_data_digit) begin
            data_ff[data_slot*4 +: 4] <= nib;
         end
      end
   end

   // Decide the line's answer
   assign dlc      = 4'(dlc_byte_ff - acp_pkg::CH_ZERO);
   assign s_ok     = (letter_ff == acp_pkg::CMD_BITRATE) && (len_ff != '0) &&
                     (b0_ff >= acp_pkg::CH_ZERO) && (b0_ff <= acp_pkg::CH_EIGHT);
   assign frame_ok = ((letter_ff == acp_pkg::CMD_EXT_TX) ||
                      (letter_ff == acp_pkg::CMD_STD_TX)) &&
                     (len_ff > LW'(idn)) && (b0_ff <= max_first) &&
                     (dlc_byte_ff >= acp_pkg::CH_ZERO) &&
                     (dlc_byte_ff <= acp_pkg::CH_EIGHT) &&
                     (int'(len_ff) == int'(idn) + 1 + 2 * int'(dlc)) && mb_ff;
   assign dfu_ok   = (letter_ff == acp_pkg::CMD_BOOT) && (len_ff >= LW'(4)) &&
                     (b0_ff == acp_pkg::CH_UNDER) && (dfu_ff == 3'b111);
   assign ack_only = (letter_ff == acp_pkg::CMD_OPEN) ||
                     (letter_ff == acp_pkg::CMD_LISTEN) ||
                     (letter_ff == acp_pkg::CMD_CLOSE);

   always_comb begin
      priority if (six) begin
         resp0 = letter_ff;
      end else if (ack_only || s_ok || frame_ok) begin
         resp0 = acp_pkg::CH_CR;
      end else if (dfu_ok) begin
         resp0 = 8'h00;
      end else begin
         resp0 = acp_pkg::CH_BEL;
      end
   end

   // Pick the byte for this result item
   assign fill_char = (letter_ff == acp_pkg::CMD_SERIAL) ? acp_pkg::CH_UPF : acp_pkg::CH_ZERO;
   assign end_char  = (letter_ff == acp_pkg::CMD_SERIAL) ? acp_pkg::CH_UPF : acp_pkg::CH_ONE;
   assign item_last = (cmd.emit_idx == (six ? acp_pkg::LAST_ITEM_LONG
                                            : acp_pkg::LAST_ITEM_SHORT));

   always_comb begin
      unique case (cmd.emit_idx)
         3'd0:                  item_byte = resp0;
         3'd1, 3'd2, 3'd3:      item_byte = fill_char;
         3'd4:                  item_byte = end_char;
         default:               item_byte = acp_pkg::CH_CR;
      endcase
   end

   // Load result register
   always_ff @(posedge clock) begin
      if (cmd.emit_load) begin
         has_ff   <= !dfu_ok;
         byte_ff  <= item_byte;
         last_ff  <= item_last;
         fv_ff    <= item_last && frame_ok;
         fext_ff  <= item_last && frame_ok && is_ext;
         fid_ff   <= (item_last && frame_ok) ? id_ff : 29'd0;
         fdlc_ff  <= (item_last && frame_ok) ? dlc : 4'd0;
         fdata_ff <= (item_last && frame_ok) ? data_ff : 64'd0;
         bv_ff    <= item_last && s_ok;
         bidx_ff  <= (item_last && s_ok) ? 4'(b0_ff - acp_pkg::CH_ZERO) : 4'd0;
         copen_ff <= open_ff;
         boot_ff  <= item_last && dfu_ok;
      end
   end

   assign rsp_has_byte           = has_ff;
   assign rsp_resp_byte          = byte_ff;
   assign rsp_last               = last_ff;
   assign rsp_frame_valid        = fv_ff;
   assign rsp_frame_extended     = fext_ff;
   assign rsp_frame_id           = fid_ff;
   assign rsp_frame_dlc          = fdlc_ff;
   assign rsp_frame_data         = fdata_ff;
   assign rsp_bitrate_valid      = bv_ff;
   assign rsp_bitrate_index      = bidx_ff;
   assign rsp_bus_open           = copen_ff;
   assign rsp_bootloader_request = boot_ff;

endmodule

`default_nettype wire

[rtl/ascii_can_command_parser.sv]
// ASCII CAN command parser: takes host command bytes and answers each line.
// A byte other than CR is taken without a stall and gives no result; the first byte of a
// line is the command letter, later bytes go into a LINE_DEPTH-entry line memory, and a
// line reaching LINE_DEPTH stored bytes is dropped. On CR the block reads the stored
// bytes back one per cycle through the single memory read port, so a CR holds the input
// stalled through the read state and a drain state for the last read (an empty line
// skips both), then through the result state while the result side takes each result:
// one result for most lines, six for the V, v and N strings. The next byte is taken in
// the cycle after the final result is loaded into the output register.
`default_nettype none

module ascii_can_command_parser #(
   parameter int LINE_DEPTH = acp_pkg::LINE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        req_mailbox_free,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_has_byte,
   output logic [7:0]       rsp_resp_byte,
   output logic             rsp_last,
   output logic             rsp_frame_valid,
   output logic             rsp_frame_extended,
   output logic [28:0]      rsp_frame_id,
   output logic [3:0]       rsp_frame_dlc,
   output logic [63:0]      rsp_frame_data,
   output logic             rsp_bitrate_valid,
   output logic [3:0]       rsp_bitrate_index,
   output logic             rsp_bus_open,
   output logic             rsp_bootloader_request
);

   localparam int LW = $clog2(LINE_DEPTH + 1);
   localparam int AW = $clog2(LINE_DEPTH);

   acp_pkg::dp_cmd_type    cmd;
   acp_pkg::dp_status_type status;
   logic [LW-1:0]          line_len;
   logic [AW-1:0]          rd_addr;

   acp_ctrl #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .status    (status),
      .line_len  (line_len),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   acp_dpath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .rd_addr                (rd_addr),
      .req_rx_byte            (req_rx_byte),
      .req_mailbox_free       (req_mailbox_free),
      .status                 (status),
      .line_len               (line_len),
      .rsp_has_byte           (rsp_has_byte),
      .rsp_resp_byte          (rsp_resp_byte),
      .rsp_last               (rsp_last),
      .rsp_frame_valid        (rsp_frame_valid),
      .rsp_frame_extended     (rsp_frame_extended),
      .rsp_frame_id           (rsp_frame_id),
      .rsp_frame_dlc          (rsp_frame_dlc),
      .rsp_frame_data         (rsp_frame_data),
      .rsp_bitrate_valid      (rsp_bitrate_valid),
      .rsp_bitrate_index      (rsp_bitrate_index),
      .rsp_bus_open           (rsp_bus_open),
      .rsp_bootloader_request (rsp_bootloader_request)
   );

`ifndef NO_ASSERTIONS
   // Only string replies have non-final items, and those always carry a byte
   a_nonlast_has_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_has_byte)
      else $error("non-final result without reply byte");

   // A sent frame is acknowledged with CR on the final item
   a_frame_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_valid |-> rsp_last && rsp_resp_byte == acp_pkg::CH_CR)
      else $error("frame sent without CR acknowledge");

   // Bootloader request is a single silent transaction
   a_boot_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bootloader_request |-> rsp_last && !rsp_has_byte)
      else $error("bootloader request with reply byte");

   // Input side stays stalled while a result burst is being produced
   a_stall_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("input taken in the middle of a reply burst");
`endif

endmodule

`default_nettype wire

[bench/ascii_can_command_parser_test.sv]
// Self-checking testbench for the ASCII CAN command parser: directed and random command lines.
`timescale 1ns / 1ps

module ascii_can_command_parser_test;

   localparam int LINE_DEPTH = acp_pkg::LINE_DEPTH_DEF;

   localparam logic [7:0] CH_NINE  = "9";
   localparam logic [7:0] CH_UPA   = "A";
   localparam logic [7:0] CH_LOWA  = "a";
   localparam logic [7:0] CH_SPACE = " ";
   localparam logic [7:0] CH_TILDE = "~";

   // One reply transaction, fields in port order
   typedef struct packed {
      logic        has_byte;
      logic [7:0]  resp_byte;
      logic        last;
      logic        frame_valid;
      logic        frame_extended;
      logic [28:0] frame_id;
      logic [3:0]  frame_dlc;
      logic [63:0] frame_data;
      logic        bitrate_valid;
      logic [3:0]  bitrate_index;
      logic        bus_open;
      logic        bootloader_request;
   } reply_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        req_mailbox_free = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_has_byte;
   logic [7:0]  rsp_resp_byte;
   logic        rsp_last;
   logic        rsp_frame_valid;
   logic        rsp_frame_extended;
   logic [28:0] rsp_frame_id;
   logic [3:0]  rsp_frame_dlc;
   logic [63:0] rsp_frame_data;
   logic        rsp_bitrate_valid;
   logic [3:0]  rsp_bitrate_index;
   logic        rsp_bus_open;
   logic        rsp_bootloader_request;

   // Parser state as seen by the host
   logic [7:0]  cmd_letter = acp_pkg::CMD_NONE;
   logic [7:0]  line_buf [0:LINE_DEPTH-1];
   int          line_len = 0;
   logic        chan_open = 1'b0;

   reply_type   pending_replies[$];
   logic [7:0]  line_bytes[$];
   int          reply_errors = 0;
   int          gap_pct = 0;
   int          stall_pct = 0;
   int          holdoff_left = 0;

   ascii_can_command_parser #(.LINE_DEPTH(LINE_DEPTH)) dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_rx_byte            (req_rx_byte),
      .req_mailbox_free       (req_mailbox_free),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_has_byte           (rsp_has_byte),
      .rsp_resp_byte          (rsp_resp_byte),
      .rsp_last               (rsp_last),
      .rsp_frame_valid        (rsp_frame_valid),
      .rsp_frame_extended     (rsp_frame_extended),
      .rsp_frame_id           (rsp_frame_id),
      .rsp_frame_dlc          (rsp_frame_dlc),
      .rsp_frame_data         (rsp_frame_data),
      .rsp_bitrate_valid      (rsp_bitrate_valid),
      .rsp_bitrate_index      (rsp_bitrate_index),
      .rsp_bus_open           (rsp_bus_open),
      .rsp_bootloader_request (rsp_bootloader_request)
   );

   always #10 clock = ~clock;

   // Hex digit value; digits keep their low nibble, letters are offset by nine
   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      if (c >= acp_pkg::CH_ZERO && c <= CH_NINE) begin
         return c[3:0];
      end
      if ((c >= CH_UPA && c <= acp_pkg::CH_UPF) ||
          (c >= CH_LOWA && c <= acp_pkg::CH_LOWF)) begin
         return 4'(c[3:0] + 4'd9);
      end
      return 4'd0;
   endfunction

   // Advance the parser by one host byte and queue the replies it causes
   function automatic void apply_host_byte(input logic [7:0] b, input logic mb);
      reply_type   r;
      logic [7:0]  text [0:5];
      logic [7:0]  lim;
      logic [7:0]  d;
      logic [31:0] id_acc;
      logic [63:0] data_acc;
      int          n;
      int          idn;
      int          dlc;
      logic        has;
      logic        fv;
      logic        fext;
      logic        bv;
      logic        boot;
      logic [3:0]  bidx;
      if (b != acp_pkg::CH_CR) begin
         if (cmd_letter != acp_pkg::CMD_NONE) begin
            line_buf[line_len % LINE_DEPTH] = b;
            line_len++;
            // drop an over-long line without a reply
            if (line_len >= LINE_DEPTH) begin
               cmd_letter = acp_pkg::CMD_NONE;
               line_len = 0;
            end
         end else begin
            cmd_letter = b;
         end
         return;
      end

      n = 1;
      has = 1'b1;
      fv = 1'b0;
      fext = 1'b0;
      bv = 1'b0;
      boot = 1'b0;
      bidx = 4'd0;
      dlc = 0;
      id_acc = '0;
      data_acc = '0;
      text[0] = acp_pkg::CH_BEL;
      case (cmd_letter)
         acp_pkg::CMD_BITRATE: begin
            if (line_len >= 1 && line_buf[0] >= acp_pkg::CH_ZERO &&
                line_buf[0] <= acp_pkg::CH_EIGHT) begin
               text[0] = acp_pkg::CH_CR;
               bv = 1'b1;
               bidx = 4'(line_buf[0] - acp_pkg::CH_ZERO);
            end
         end
         acp_pkg::CMD_OPEN, acp_pkg::CMD_LISTEN: begin
            chan_open = 1'b1;
            text[0] = acp_pkg::CH_CR;
         end
         acp_pkg::CMD_CLOSE: begin
            chan_open = 1'b0;
            text[0] = acp_pkg::CH_CR;
         end
         acp_pkg::CMD_VER_HW, acp_pkg::CMD_VER_SW, acp_pkg::CMD_SERIAL: begin
            d = (cmd_letter == acp_pkg::CMD_SERIAL) ? acp_pkg::CH_UPF : acp_pkg::CH_ZERO;
            text[0] = cmd_letter;
            text[1] = d;
            text[2] = d;
            text[3] = d;
            text[4] = (cmd_letter == acp_pkg::CMD_SERIAL) ? acp_pkg::CH_UPF : acp_pkg::CH_ONE;
            text[5] = acp_pkg::CH_CR;
            n = 6;
         end
         acp_pkg::CMD_EXT_TX, acp_pkg::CMD_STD_TX: begin
            fext = (cmd_letter == acp_pkg::CMD_EXT_TX);
            idn = fext ? int'(acp_pkg::ID_DIGITS_EXT) : int'(acp_pkg::ID_DIGITS_STD);
            lim = fext ? acp_pkg::CH_ONE : acp_pkg::CH_SEVEN;
            if (line_len > idn && line_buf[0] <= lim &&
                line_buf[idn] >= acp_pkg::CH_ZERO && line_buf[idn] <= acp_pkg::CH_EIGHT) begin
               dlc = int'(line_buf[idn] - acp_pkg::CH_ZERO);
               // send only a complete frame, and only into a free mailbox
               if (line_len == idn + 1 + 2 * dlc && mb) begin
                  for (int i = 0; i < idn; i++) begin
                     id_acc = {id_acc[27:0], nibble_of(line_buf[i])};
                  end
                  for (int i = 0; i < dlc; i++) begin
                     data_acc[8*i +: 8] = {nibble_of(line_buf[idn + 1 + 2*i]),
                                           nibble_of(line_buf[idn + 2 + 2*i])};
                  end
                  fv = 1'b1;
                  text[0] = acp_pkg::CH_CR;
               end
            end
         end
         acp_pkg::CMD_BOOT: begin
            if (line_len >= 4 && line_buf[0] == acp_pkg::CH_UNDER &&
                line_buf[1] == acp_pkg::CH_LOWD && line_buf[2] == acp_pkg::CH_LOWF &&
                line_buf[3] == acp_pkg::CH_LOWU) begin
               boot = 1'b1;
               has = 1'b0;
               text[0] = '0;
            end
         end
         default: begin
         end
      endcase
      cmd_letter = acp_pkg::CMD_NONE;
      line_len = 0;

      // frame, bitrate and bootloader fields ride on the final reply only
      for (int k = 0; k < n; k++) begin
         r = '0;
         r.has_byte = has;
         r.resp_byte = text[k];
         r.bus_open = chan_open;
         if (k == n - 1) begin
            r.last = 1'b1;
            r.frame_valid = fv;
            r.frame_extended = fext & fv;
            r.frame_id = id_acc[28:0];
            r.frame_dlc = fv ? 4'(dlc) : 4'd0;
            r.frame_data = data_acc;
            r.bitrate_valid = bv;
            r.bitrate_index = bidx;
            r.bootloader_request = boot;
         end
         pending_replies.push_back(r);
      end
   endfunction

   function automatic string reply_text(input reply_type r);
      return {$sformatf("has=%0b byte=%h last=%0b fv=%0b ext=%0b id=%h dlc=%0d ",
                        r.has_byte, r.resp_byte, r.last, r.frame_valid,
                        r.frame_extended, r.frame_id, r.frame_dlc),
              $sformatf("data=%h brv=%0b bri=%0d open=%0b boot=%0b",
                        r.frame_data, r.bitrate_valid, r.bitrate_index,
                        r.bus_open, r.bootloader_request)};
   endfunction

   // Receiver: long hold-off first, otherwise stall at random
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // Check each reply transaction against the oldest expectation
   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_has_byte, rsp_resp_byte, rsp_last, rsp_frame_valid, rsp_frame_extended,
                rsp_frame_id, rsp_frame_dlc, rsp_frame_data, rsp_bitrate_valid,
                rsp_bitrate_index, rsp_bus_open, rsp_bootloader_request};
         if (pending_replies.size() == 0) begin
            reply_errors++;
            if (reply_errors <= 10) begin
               $display("unexpected reply: %s", reply_text(got));
            end
         end else begin
            want = pending_replies.pop_front();
            if (got !== want) begin
               reply_errors++;
               if (reply_errors <= 10) begin
                  $display("reply differs, expected: %s", reply_text(want));
                  $display("                 actual: %s", reply_text(got));
               end
            end
         end
      end
   end

   // Offer one byte, hold it until taken, then predict
   task automatic send_host_byte(input logic [7:0] b, input logic mb);
      @(negedge clock);
      while ($urandom_range(99) < gap_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_rx_byte = b;
      req_mailbox_free = mb;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      apply_host_byte(b, mb);
   endtask

   task automatic send_queued_line(input int mb_pct);
      for (int i = 0; i < line_bytes.size(); i++) begin
         send_host_byte(line_bytes[i], $urandom_range(99) < mb_pct);
      end
      line_bytes.delete();
   endtask

   // Drop valid, wait for every reply, then let the block settle
   task automatic wait_replies_done();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_replies.size() != 0) begin
         @(posedge clock);
      end
      repeat (LINE_DEPTH + 8) @(posedge clock);
   endtask

   function automatic logic [7:0] random_hex_char();
      int v;
      v = $urandom_range(15);
      if ($urandom_range(19) == 0) begin
         return 8'($urandom_range(255));
      end
      if (v < 10) begin
         return 8'(acp_pkg::CH_ZERO + v);
      end
      return $urandom_range(1) ? 8'(CH_UPA + v - 10) : 8'(CH_LOWA + v - 10);
   endfunction

   function automatic logic [7:0] printable_char();
      return 8'($urandom_range(CH_TILDE, CH_SPACE));
   endfunction

   // Build one command line ending in CR, mostly well formed
   function automatic void build_random_line();
      int   kind;
      int   n;
      int   dlc;
      int   idn;
      logic ext;
      logic extreme;
      kind = $urandom_range(99);
      if (kind < 28) begin
         ext = $urandom_range(1);
         idn = ext ? int'(acp_pkg::ID_DIGITS_EXT) : int'(acp_pkg::ID_DIGITS_STD);
         extreme = ($urandom_range(7) == 0);
         dlc = extreme ? 8 : $urandom_range(8);
         line_bytes.push_back(ext ? acp_pkg::CMD_EXT_TX : acp_pkg::CMD_STD_TX);
         // first id digit, within its limit most of the time
         if (extreme) begin
            line_bytes.push_back(ext ? acp_pkg::CH_ONE : acp_pkg::CH_SEVEN);
         end else if ($urandom_range(9) == 0) begin
            line_bytes.push_back(random_hex_char());
         end else begin
            line_bytes.push_back(8'(acp_pkg::CH_ZERO + $urandom_range(ext ? 1 : 7)));
         end
         for (int i = 1; i < idn; i++) begin
            line_bytes.push_back(extreme ? acp_pkg::CH_UPF : random_hex_char());
         end
         // length digit, now and then out of range
         case ($urandom_range(11))
            0: line_bytes.push_back(CH_NINE);
            1: line_bytes.push_back(printable_char());
            default: line_bytes.push_back(8'(acp_pkg::CH_ZERO + dlc));
         endcase
         n = 2 * dlc;
         case ($urandom_range(9))
            0: n = n + 1;
            1: n = (n > 0) ? n - 1 : n;
            default: begin
            end
         endcase
         for (int i = 0; i < n; i++) begin
            line_bytes.push_back(extreme ? ((i % 2) ? acp_pkg::CH_LOWF : acp_pkg::CH_UPF)
                                         : random_hex_char());
         end
      end else if (kind < 38) begin
         line_bytes.push_back(acp_pkg::CMD_BITRATE);
         case ($urandom_range(5))
            0: begin
            end
            1: line_bytes.push_back(8'($urandom_range(255)));
            default: line_bytes.push_back(8'(acp_pkg::CH_ZERO + $urandom_range(9)));
         endcase
         if ($urandom_range(4) == 0) begin
            line_bytes.push_back(random_hex_char());
         end
      end else if (kind < 52) begin
         case ($urandom_range(2))
            0: line_bytes.push_back(acp_pkg::CMD_OPEN);
            1: line_bytes.push_back(acp_pkg::CMD_LISTEN);
            default: line_bytes.push_back(acp_pkg::CMD_CLOSE);
         endcase
         if ($urandom_range(5) == 0) begin
            line_bytes.push_back(printable_char());
         end
      end else if (kind < 62) begin
         case ($urandom_range(2))
            0: line_bytes.push_back(acp_pkg::CMD_VER_HW);
            1: line_bytes.push_back(acp_pkg::CMD_VER_SW);
            default: line_bytes.push_back(acp_pkg::CMD_SERIAL);
         endcase
      end else if (kind < 70) begin
         line_bytes.push_back(acp_pkg::CMD_BOOT);
         line_bytes.push_back(acp_pkg::CH_UNDER);
         line_bytes.push_back(acp_pkg::CH_LOWD);
         line_bytes.push_back(acp_pkg::CH_LOWF);
         line_bytes.push_back(acp_pkg::CH_LOWU);
         // break the keyword now and then
         case ($urandom_range(5))
            0: line_bytes[$urandom_range(4, 1)] = printable_char();
            1: void'(line_bytes.pop_back());
            2: line_bytes.push_back(printable_char());
            default: begin
            end
         endcase
      end else if (kind < 84) begin
         n = $urandom_range(6);
         for (int i = 0; i <= n; i++) begin
            line_bytes.push_back(8'($urandom_range(255)));
         end
      end else if (kind < 91) begin
         // store from one byte short of the line depth to eight past it; all but the shortest are dropped
         line_bytes.push_back(8'($urandom_range(acp_pkg::CH_UPF, CH_UPA)));
         n = $urandom_range(LINE_DEPTH + 8, LINE_DEPTH - 1);
         for (int i = 0; i < n; i++) begin
            line_bytes.push_back(printable_char());
         end
      end else begin
         // a zero byte leaves no command, so the next byte starts the line
         line_bytes.push_back(acp_pkg::CMD_NONE);
         line_bytes.push_back($urandom_range(1) ? acp_pkg::CMD_OPEN : acp_pkg::CMD_VER_SW);
      end
      line_bytes.push_back(acp_pkg::CH_CR);
   endfunction

   task automatic test_directed_lines();
      string lines [0:7];
      lines = '{"S8", "O", "V", "N", "t7FF0", "", "__dfu", "C"};
      gap_pct = 0;
      stall_pct = 0;
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < lines[i].len(); j++) begin
            line_bytes.push_back(lines[i][j]);
         end
         line_bytes.push_back(acp_pkg::CH_CR);
         send_queued_line(100);
      end
      wait_replies_done();
   endtask

   task automatic test_random_lines(input int gap, input int stall, input int nbytes);
      int sent;
      gap_pct = gap;
      stall_pct = stall;
      sent = 0;
      while (sent < nbytes) begin
         build_random_line();
         sent += line_bytes.size();
         send_queued_line(85);
      end
      wait_replies_done();
   endtask

   // Hold the reply side for a long stretch while the host keeps sending
   task automatic test_long_holdoff();
      gap_pct = 0;
      stall_pct = 0;
      holdoff_left = 300;
      for (int i = 0; i < 8; i++) begin
         if (i % 2 == 0) begin
            line_bytes.push_back((i % 4 == 0) ? acp_pkg::CMD_VER_HW : acp_pkg::CMD_SERIAL);
            line_bytes.push_back(acp_pkg::CH_CR);
         end else begin
            build_random_line();
         end
         send_queued_line(85);
      end
      wait_replies_done();
   endtask

   initial begin
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed_lines();
      test_random_lines(37, 61, 125);
      test_random_lines(61, 37, 125);
      test_random_lines(0, 0, 125);
      test_long_holdoff();
      if (reply_errors == 0) begin
         $display("ascii_can_command_parser: match");
      end else begin
         $display("ascii_can_command_parser: mismatch");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("ascii_can_command_parser: mismatch");
      $finish;
   end

endmodule
